// File: rtl/vfv_pkg.sv
// Shared types and constants for the voxel face visibility mask block.
`timescale 1ns / 1ps

package vfv_pkg;

    // Largest interior edge length of a chunk.
    localparam int DEF_MAX_INTERIOR = 32;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_GRID_DEPTH  = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int POS_W      = 5;
    localparam int MASK_W     = 6;

    // Face mask bit positions.
    localparam int BIT_PX = 0;
    localparam int BIT_NX = 1;
    localparam int BIT_PY = 2;
    localparam int BIT_NY = 3;
    localparam int BIT_PZ = 4;
    localparam int BIT_NZ = 5;

    // Size taken after reset, before clamping.
    localparam int RST_SIZE = 34;

    typedef logic [MASK_W-1:0] t_mask;
    typedef logic [POS_W-1:0]  t_pos;

endpackage

// File: rtl/vfv_if.sv
// Stream and configuration channel interfaces of the voxel face visibility block.
`timescale 1ns / 1ps

interface vfv_in_if;
    logic valid;
    logic ready;
    logic transparent;

    modport source (output valid, output transparent, input ready);
    modport sink   (input valid, input transparent, output ready);
endinterface

interface vfv_out_if;
    logic                 valid;
    logic                 ready;
    logic [5:0]           face_mask;
    logic                 any_visible;
    logic [4:0]           pos_x;
    logic [4:0]           pos_y;
    logic [4:0]           pos_z;
    logic                 last;

    modport source (output valid, output face_mask, output any_visible, output pos_x,
                    output pos_y, output pos_z, output last, input ready);
    modport sink   (input valid, input face_mask, input any_visible, input pos_x,
                    input pos_y, input pos_z, input last, output ready);
endinterface

interface vfv_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [5:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/voxel_face_visibility_mask.sv
// Top level: streamed six-neighbour face visibility mask over a padded voxel chunk.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------------
//  i_in     | in  | valid / ready | transparent
//  o_out    | out | valid / ready | face_mask, any_visible, pos_x, pos_y, pos_z, last
//  i_cfg    | in  | valid / ready | index (0 width, 1 height, 2 depth), data
//
//  One voxel per clock unless held off; the result of a voxel is in the output register
//  the cycle after its transfer. Neighbor bits come from two circular bit buffers (one write
//  and one registered read each per transfer), so the input rate is set by those buffer ports.
//  Reset clears the counters, read pointers and output valid; buffer contents need no clearing.
//  Input is held off only while a result waits in the output register and o_out.ready is low.
//  A config write restarts the raster position at the chunk origin.

module voxel_face_visibility_mask #(
    parameter int MAX_INTERIOR = vfv_pkg::DEF_MAX_INTERIOR
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vfv_in_if.sink     i_in,
    vfv_out_if.source  o_out,
    vfv_cfg_if.sink    i_cfg
);
    import vfv_pkg::*;

    localparam int PAD     = MAX_INTERIOR + 2;
    localparam int ZW      = $clog2(PAD + 1);
    localparam int XW      = (ZW > CFG_DATA_W) ? ZW : CFG_DATA_W;
    localparam int PW      = (ZW > POS_W) ? ZW : POS_W;
    localparam int D1      = PAD * (PAD - 1);
    localparam int A1      = $clog2(D1);
    localparam int D2      = PAD - 1;
    localparam int A2      = $clog2(D2);
    localparam int RST_SZ  = (PAD < RST_SIZE) ? PAD : RST_SIZE;
    localparam int RST_L1M = RST_SZ * (RST_SZ - 1) - 1;
    localparam int RST_L2M = RST_SZ - 2;

    function automatic logic [ZW-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v);
        logic [XW-1:0] ve;
        ve = XW'(v);
        if (ve < XW'(3)) return ZW'(3);
        if (ve > XW'(PAD)) return ZW'(PAD);
        return ZW'(ve);
    endfunction

    // ---------------- configuration ----------------
    logic [ZW-1:0] r_w, r_h, r_dep;
    logic [ZW-1:0] n_w, n_h, n_dep;
    logic          cfg_hit;
    logic [2*ZW-1:0] n_prod;
    logic [A1-1:0] n_len1m, r_len1m;
    logic [A2-1:0] n_len2m, r_len2m;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_w     = r_w;
        n_h     = r_h;
        n_dep   = r_dep;
        cfg_hit = 1'b0;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_GRID_WIDTH: begin
                    n_w     = clamp_size(i_cfg.data);
                    cfg_hit = 1'b1;
                end
                REG_GRID_HEIGHT: begin
                    n_h     = clamp_size(i_cfg.data);
                    cfg_hit = 1'b1;
                end
                REG_GRID_DEPTH: begin
                    n_dep   = clamp_size(i_cfg.data);
                    cfg_hit = 1'b1;
                end
                default: ;
            endcase
        end
        // Plane delay minus one row: w*(h-1); the row delay is w-1.
        n_prod  = (2*ZW)'(n_w) * (2*ZW)'(n_h - ZW'(1));
        n_len1m = A1'(n_prod - (2*ZW)'(1));
        n_len2m = A2'(n_w - ZW'(2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= clamp_size(CFG_DATA_W'(RST_SIZE));
            r_h     <= clamp_size(CFG_DATA_W'(RST_SIZE));
            r_dep   <= clamp_size(CFG_DATA_W'(RST_SIZE));
            r_len1m <= A1'(RST_L1M);
            r_len2m <= A2'(RST_L2M);
        end else if (cfg_hit) begin
            r_w     <= n_w;
            r_h     <= n_h;
            r_dep   <= n_dep;
            r_len1m <= n_len1m;
            r_len2m <= n_len2m;
        end
    end

    // ---------------- handshake ----------------
    logic r_ov;
    logic in_ready, in_xfer;

    assign in_ready   = !r_ov || o_out.ready;
    assign i_in.ready = in_ready;
    assign in_xfer    = i_in.valid && in_ready;

    // ---------------- raster position ----------------
    logic [ZW-1:0] r_cx, r_cy, r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
        end else if (in_xfer) begin
            if (r_cx == r_w - ZW'(1)) begin
                r_cx <= '0;
                if (r_cy == r_h - ZW'(1)) begin
                    r_cy <= '0;
                    r_cz <= (r_cz == r_dep - ZW'(1)) ? '0 : r_cz + ZW'(1);
                end else begin
                    r_cy <= r_cy + ZW'(1);
                end
            end else begin
                r_cx <= r_cx + ZW'(1);
            end
        end
    end

    // ---------------- delay line ----------------
    // Buffer 1 (length w*(h-1)): bit 0 carries the input stream, bit 1 carries the -y tap on to -z.
    // Buffer 2 (length w-1): bit 0 continues bit 0 of buffer 1, bit 1 follows the -x tap.
    logic [1:0]    mem1 [D1];
    logic [1:0]    mem2 [D2];
    logic [A1-1:0] r_wp1, r_rp1;
    logic [A2-1:0] r_wp2, r_rp2;
    logic [1:0]    r_q1, r_q2;
    logic          r_tap_c, r_tap_nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp1 <= A1'(RST_L1M);
            r_rp1 <= '0;
            r_wp2 <= A2'(RST_L2M);
            r_rp2 <= '0;
        end else if (cfg_hit) begin
            r_wp1 <= n_len1m;
            r_rp1 <= '0;
            r_wp2 <= n_len2m;
            r_rp2 <= '0;
        end else if (in_xfer) begin
            r_wp1 <= (r_wp1 == A1'(D1 - 1)) ? '0 : r_wp1 + A1'(1);
            r_rp1 <= (r_rp1 == A1'(D1 - 1)) ? '0 : r_rp1 + A1'(1);
            r_wp2 <= (r_wp2 == A2'(D2 - 1)) ? '0 : r_wp2 + A2'(1);
            r_rp2 <= (r_rp2 == A2'(D2 - 1)) ? '0 : r_rp2 + A2'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            mem1[r_wp1] <= {r_q2[1], i_in.transparent};
            r_q1        <= mem1[r_rp1];
            mem2[r_wp2] <= {r_tap_nx, r_q1[0]};
            r_q2        <= mem2[r_rp2];
            r_tap_c     <= r_q2[0];
            r_tap_nx    <= r_tap_c;
        end
    end

    // ---------------- result ----------------
    logic  res_valid, res_last;
    t_mask res_mask;
    logic [PW-1:0] ext_x, ext_y, ext_z;

    always_comb begin
        res_valid = (r_cz >= ZW'(2)) && (r_cx >= ZW'(1)) && (r_cx <= r_w - ZW'(2)) &&
                    (r_cy >= ZW'(1)) && (r_cy <= r_h - ZW'(2));
        res_last  = (r_cx == r_w - ZW'(2)) && (r_cy == r_h - ZW'(2)) &&
                    (r_cz == r_dep - ZW'(1));
        res_mask          = '0;
        res_mask[BIT_PX]  = r_q2[0];
        res_mask[BIT_NX]  = r_tap_nx;
        res_mask[BIT_PY]  = r_q1[0];
        res_mask[BIT_NY]  = r_q2[1];
        res_mask[BIT_PZ]  = i_in.transparent;
        res_mask[BIT_NZ]  = r_q1[1];
        ext_x = PW'(r_cx) - PW'(1);
        ext_y = PW'(r_cy) - PW'(1);
        ext_z = PW'(r_cz) - PW'(2);
    end

    t_mask r_mask;
    logic  r_any, r_last;
    t_pos  r_px, r_py, r_pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (in_xfer) begin
            r_ov <= res_valid;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && res_valid) begin
            r_mask <= res_mask;
            r_any  <= |res_mask;
            r_px   <= ext_x[POS_W-1:0];
            r_py   <= ext_y[POS_W-1:0];
            r_pz   <= ext_z[POS_W-1:0];
            r_last <= res_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.face_mask   = r_mask;
    assign o_out.any_visible = r_any;
    assign o_out.pos_x       = r_px;
    assign o_out.pos_y       = r_py;
    assign o_out.pos_z       = r_pz;
    assign o_out.last        = r_last;

    // ---------------- assertions ----------------
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cx < r_w) && (r_cy < r_h) && (r_cz < r_dep))
        else $error("raster position outside grid");

    a_buf1_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wp1 >= r_rp1) ? (int'(r_wp1) - int'(r_rp1))
                          : (int'(r_wp1) + D1 - int'(r_rp1))) == int'(r_len1m))
        else $error("plane buffer pointers out of step");

    a_buf2_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_wp2 >= r_rp2) ? (int'(r_wp2) - int'(r_rp2))
                          : (int'(r_wp2) + D2 - int'(r_rp2))) == int'(r_len2m))
        else $error("row buffer pointers out of step");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && res_valid) |=> r_ov)
        else $error("result lost after transfer");

    a_any_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_any == (r_mask != '0)))
        else $error("any_visible disagrees with face_mask");

endmodule
